// ===== design/swgc_pkg.sv =====
// Shared types and constants for the sliding-window G/C histogram.
// Item structs for both channels, result status codes, base classifier.
// No dependencies.
package swgc_pkg;

	localparam int CFG_W = 11;
	localparam int BIN_IDX_W = 11;
	localparam int GC_W = 11;
	localparam int BIN_CNT_W = 32;
	localparam int TOTAL_W = 48;

	localparam int RSP_DEPTH = 4;
	localparam int RSP_PTR_W = 2;
	localparam int RSP_CNT_W = 3;

	localparam logic [7:0] CH_A_LO = 8'h61;
	localparam logic [7:0] CH_A_UP = 8'h41;
	localparam logic [7:0] CH_C_LO = 8'h63;
	localparam logic [7:0] CH_C_UP = 8'h43;
	localparam logic [7:0] CH_G_LO = 8'h67;
	localparam logic [7:0] CH_G_UP = 8'h47;
	localparam logic [7:0] CH_T_LO = 8'h74;
	localparam logic [7:0] CH_T_UP = 8'h54;

	typedef enum logic [1:0] {
		ST_NO_WINDOW = 2'd0,
		ST_WINDOW    = 2'd1,
		ST_BAD_BASE  = 2'd2,
		ST_BIN_READ  = 2'd3
	} status_t;

	typedef struct packed {
		logic                 mode;
		logic [7:0]           base;
		logic                 first_of_region;
		logic [BIN_IDX_W-1:0] bin_index;
	} req_item_t;

	typedef struct packed {
		status_t              status;
		logic [GC_W-1:0]      gc_count;
		logic [BIN_CNT_W-1:0] bin_count;
		logic [TOTAL_W-1:0]   total_windows;
	} rsp_item_t;

	// histogram access issued in stage 1
	typedef struct packed {
		logic en;
		logic clear;   // 1: read and clear, 0: saturating increment
	} hist_req_t;

	typedef struct packed {
		logic valid;
		logic gc;
	} base_class_t;

	function automatic base_class_t classify(input logic [7:0] b);
		base_class_t r;
		r = '0;
		case (b) inside
			CH_C_LO, CH_C_UP, CH_G_LO, CH_G_UP: begin
				r.valid = 1'b1;
				r.gc = 1'b1;
			end
			CH_A_LO, CH_A_UP, CH_T_LO, CH_T_UP: begin
				r.valid = 1'b1;
				r.gc = 1'b0;
			end
			default: begin
				r = '0;
			end
		endcase
		return r;
	endfunction

endpackage

// ===== design/sliding_window_gc_histogram.sv =====
// Sliding-window G/C histogram, top level. Items pass stage 1 and stage 2 into
// the result queue. One item per cycle while req_ready is high (low while the
// clear runs or the queue lacks room), set by the ring and histogram memories
// each taking one read and one write per cycle. Reset: control clears at once,
// then a pass zeroes all MAX_WINDOW+1 bins (1025 by default), req_ready low meanwhile.
// Depends on swgc_pkg and swgc_hist.
module sliding_window_gc_histogram #(
	parameter int MAX_WINDOW = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  swgc_pkg::req_item_t        req,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output swgc_pkg::rsp_item_t        rsp,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [swgc_pkg::CFG_W-1:0] cfg_data
);

	localparam int WL_W = $clog2(MAX_WINDOW + 1);
	localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int TW = swgc_pkg::TOTAL_W;

	// configuration
	logic [WL_W-1:0] wl_q;
	logic [31:0]     cfg_ext;
	logic [31:0]     cfg_clamped;
	logic            cfg_wr;

	// region state
	logic [PTR_W-1:0] ptr_q;
	logic [WL_W-1:0]  fill_q;
	logic [WL_W-1:0]  sum_q;
	logic [TW-1:0]    total_q;

	// stage 0
	logic                  acc;
	swgc_pkg::base_class_t cls;
	logic                  restart0;
	logic                  upd0;
	logic [WL_W-1:0]       slot_w;
	logic [WL_W-1:0]       slot_nx;
	logic [WL_W-1:0]       fill0;
	logic [WL_W-1:0]       fill_inc;
	logic [31:0]           bin_ext;

	// ring memory
	logic ring_mem [0:MAX_WINDOW-1];
	logic ring_rd_s1;

	// stage 1
	logic            v_s1;
	logic            mode_s1;
	logic            good_s1;
	logic            restart_s1;
	logic            gc_s1;
	logic            sub_s1;
	logic            done_s1;
	logic            binok_s1;
	logic [WL_W-1:0] bin_addr_s1;
	logic [WL_W-1:0] sum_base;
	logic [WL_W-1:0] sum_new;
	logic            win_s1;
	logic [TW-1:0]   total_nx;
	swgc_pkg::status_t status_s1;
	swgc_pkg::hist_req_t hreq;
	logic [WL_W-1:0] haddr;

	// stage 2
	logic                            v_s2;
	swgc_pkg::status_t               status_s2;
	logic [swgc_pkg::GC_W-1:0]       gc_s2;
	logic [TW-1:0]                   total_s2;
	logic                            binrd_s2;
	logic [swgc_pkg::BIN_CNT_W-1:0]  hist_old;
	logic                            clr_busy;
	swgc_pkg::rsp_item_t             rsp_s2;

	// result queue
	swgc_pkg::rsp_item_t              rq_mem [swgc_pkg::RSP_DEPTH];
	logic [swgc_pkg::RSP_PTR_W-1:0]   rq_wr_q;
	logic [swgc_pkg::RSP_PTR_W-1:0]   rq_rd_q;
	logic [swgc_pkg::RSP_CNT_W-1:0]   rq_cnt_q;
	logic [swgc_pkg::RSP_CNT_W-1:0]   occupancy;
	logic                             rq_pop;

	// ---------------- configuration ----------------
	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid & cfg_ready;
	assign cfg_ext = 32'(cfg_data);

	always_comb begin
		if (cfg_ext == 32'd0) begin
			cfg_clamped = 32'd1;
		end else if (cfg_ext > 32'(MAX_WINDOW)) begin
			cfg_clamped = 32'(MAX_WINDOW);
		end else begin
			cfg_clamped = cfg_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q <= WL_W'(1);
		end else if (cfg_wr) begin
			wl_q <= cfg_clamped[WL_W-1:0];
		end
	end

	// ---------------- stage 0 ----------------
	assign occupancy = rq_cnt_q + swgc_pkg::RSP_CNT_W'(v_s1) + swgc_pkg::RSP_CNT_W'(v_s2);
	assign req_ready = !clr_busy && (occupancy < swgc_pkg::RSP_CNT_W'(swgc_pkg::RSP_DEPTH));
	assign acc = req_valid & req_ready;

	assign cls = swgc_pkg::classify(req.base);
	assign restart0 = !req.mode & req.first_of_region;
	assign upd0 = acc & !req.mode & cls.valid;

	always_comb begin
		if (restart0 || WL_W'(ptr_q) >= wl_q) begin
			slot_w = '0;
		end else begin
			slot_w = WL_W'(ptr_q);
		end
		fill0 = restart0 ? '0 : fill_q;
		fill_inc = (fill0 < wl_q) ? fill0 + WL_W'(1) : fill0;
		slot_nx = slot_w + WL_W'(1);
	end

	assign bin_ext = 32'(req.bin_index);

	always_ff @(posedge clk) begin
		if (upd0) begin
			ring_rd_s1 <= ring_mem[slot_w[PTR_W-1:0]];
			ring_mem[slot_w[PTR_W-1:0]] <= cls.gc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			fill_q <= '0;
		end else if (cfg_wr) begin
			ptr_q <= '0;
			fill_q <= '0;
		end else if (upd0) begin
			ptr_q <= (slot_nx >= wl_q) ? '0 : slot_nx[PTR_W-1:0];
			fill_q <= fill_inc;
		end else if (acc && restart0) begin
			ptr_q <= '0;
			fill_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		mode_s1 <= req.mode;
		good_s1 <= cls.valid;
		restart_s1 <= restart0;
		gc_s1 <= cls.gc;
		sub_s1 <= (fill0 >= wl_q);
		done_s1 <= (fill_inc >= wl_q);
		binok_s1 <= (bin_ext <= 32'(MAX_WINDOW));
		bin_addr_s1 <= bin_ext[WL_W-1:0];
	end

	// ---------------- stage 1 ----------------
	always_comb begin
		sum_base = restart_s1 ? '0 : sum_q;
		sum_new = sum_base - WL_W'(sub_s1 & ring_rd_s1) + WL_W'(gc_s1);
		win_s1 = v_s1 & !mode_s1 & good_s1 & done_s1;
		total_nx = (win_s1 && total_q != '1) ? total_q + TW'(1) : total_q;
		if (mode_s1) begin
			status_s1 = swgc_pkg::ST_BIN_READ;
		end else if (!good_s1) begin
			status_s1 = swgc_pkg::ST_BAD_BASE;
		end else if (done_s1) begin
			status_s1 = swgc_pkg::ST_WINDOW;
		end else begin
			status_s1 = swgc_pkg::ST_NO_WINDOW;
		end
		hreq.en = v_s1 & (mode_s1 ? binok_s1 : (good_s1 & done_s1));
		hreq.clear = mode_s1;
		haddr = mode_s1 ? bin_addr_s1 : sum_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			sum_q <= '0;
			total_q <= '0;
		end else begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			total_q <= total_nx;
			if (cfg_wr) begin
				sum_q <= '0;
			end else if (v_s1 && !mode_s1) begin
				sum_q <= good_s1 ? sum_new : sum_base;
			end
		end
	end

	always_ff @(posedge clk) begin
		status_s2 <= status_s1;
		gc_s2 <= win_s1 ? swgc_pkg::GC_W'(sum_new) : '0;
		total_s2 <= total_nx;
		binrd_s2 <= mode_s1 & binok_s1;
	end

	swgc_hist #(
		.MAX_WINDOW(MAX_WINDOW),
		.ADDR_W(WL_W)
	) u_hist (
		.clk(clk),
		.arst_n(arst_n),
		.req(hreq),
		.addr(haddr),
		.old_value(hist_old),
		.busy(clr_busy)
	);

	// ---------------- stage 2 and result queue ----------------
	always_comb begin
		rsp_s2.status = status_s2;
		rsp_s2.gc_count = gc_s2;
		rsp_s2.bin_count = binrd_s2 ? hist_old : '0;
		rsp_s2.total_windows = total_s2;
	end

	assign rsp_valid = (rq_cnt_q != '0);
	assign rsp = rq_mem[rq_rd_q];
	assign rq_pop = rsp_valid & rsp_ready;

	always_ff @(posedge clk) begin
		if (v_s2) begin
			rq_mem[rq_wr_q] <= rsp_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_wr_q <= '0;
			rq_rd_q <= '0;
			rq_cnt_q <= '0;
		end else begin
			if (v_s2) begin
				rq_wr_q <= rq_wr_q + swgc_pkg::RSP_PTR_W'(1);
			end
			if (rq_pop) begin
				rq_rd_q <= rq_rd_q + swgc_pkg::RSP_PTR_W'(1);
			end
			rq_cnt_q <= rq_cnt_q + swgc_pkg::RSP_CNT_W'(v_s2) - swgc_pkg::RSP_CNT_W'(rq_pop);
		end
	end

	a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !req_ready)
		else $error("item accepted during clearing pass");

	a_sum_within_window: assert property (@(posedge clk) disable iff (!arst_n)
		sum_q <= wl_q)
		else $error("window sum exceeds window length");

	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> rq_cnt_q != swgc_pkg::RSP_CNT_W'(swgc_pkg::RSP_DEPTH))
		else $error("result queue overflow");

endmodule

// ===== design/swgc_hist.sv =====
// Histogram store: one synchronous memory of saturating 32-bit bins with
// read-modify-write, write forwarding and a clearing pass after reset.
// Depends on swgc_pkg.
module swgc_hist #(
	parameter int MAX_WINDOW = 1024,
	parameter int ADDR_W = 11
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  swgc_pkg::hist_req_t            req,
	input  logic [ADDR_W-1:0]              addr,
	output logic [swgc_pkg::BIN_CNT_W-1:0] old_value,
	output logic                           busy
);

	localparam int DW = swgc_pkg::BIN_CNT_W;

	logic [DW-1:0]     hist_mem [0:MAX_WINDOW];
	logic [DW-1:0]     rdata_s2;
	swgc_pkg::hist_req_t req_s2;
	logic [ADDR_W-1:0] addr_s2;

	logic [ADDR_W-1:0] clr_cnt_q;
	logic              busy_q;

	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [DW-1:0]     wr_data;
	logic              wr_en_q;
	logic [ADDR_W-1:0] wr_addr_q;
	logic [DW-1:0]     wr_data_q;

	logic [DW-1:0]     cur;

	assign busy = busy_q;

	// newest value of the entry: last write wins over the memory read
	assign cur = (wr_en_q && wr_addr_q == addr_s2) ? wr_data_q : rdata_s2;
	assign old_value = cur;

	always_comb begin
		wr_en = busy_q | req_s2.en;
		wr_addr = busy_q ? clr_cnt_q : addr_s2;
		if (busy_q || req_s2.clear) begin
			wr_data = '0;
		end else if (cur == '1) begin
			wr_data = cur;
		end else begin
			wr_data = cur + DW'(1);
		end
	end

	always_ff @(posedge clk) begin
		rdata_s2 <= hist_mem[addr];
		if (wr_en) begin
			hist_mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		addr_s2 <= addr;
		wr_addr_q <= wr_addr;
		wr_data_q <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s2 <= '0;
			wr_en_q <= 1'b0;
			busy_q <= 1'b1;
			clr_cnt_q <= '0;
		end else begin
			req_s2 <= req;
			wr_en_q <= wr_en;
			if (busy_q) begin
				if (32'(clr_cnt_q) == MAX_WINDOW) begin
					busy_q <= 1'b0;
				end else begin
					clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
				end
			end
		end
	end

	a_no_req_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !req.en)
		else $error("histogram access during clearing pass");

	a_clear_covers_all: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> 32'($past(clr_cnt_q)) == MAX_WINDOW)
		else $error("clearing pass ended early");

endmodule

// ===== bench/tb_sliding_window_gc_histogram.sv =====
// Testbench for sliding_window_gc_histogram: directed and random base streams and bin reads,
// checked item by item against a scoreboard that models the ring, window sum and histogram.
// Depends on swgc_pkg and the design sources.
module tb_sliding_window_gc_histogram;

	localparam int MAX_WIN = 1024;
	localparam int QUIET_LIMIT = 4000;

	class gc_hist_scoreboard;
		bit                         gc_ring [MAX_WIN];
		bit [31:0]                  hist [MAX_WIN + 1];
		bit [swgc_pkg::TOTAL_W-1:0] total;
		int unsigned                wl = 1;
		int unsigned                ring_ptr;
		int unsigned                fill;
		int unsigned                gc_sum;
		int                         errors;
		swgc_pkg::rsp_item_t        pending_results [$];

		function void restart_region();
			ring_ptr = 0;
			fill = 0;
			gc_sum = 0;
		endfunction

		function void write_window(logic [swgc_pkg::CFG_W-1:0] v);
			if (v == 0)
				wl = 1;
			else if (v > MAX_WIN)
				wl = MAX_WIN;
			else
				wl = 32'(v);
			restart_region();
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		function void note_item(swgc_pkg::req_item_t it);
			swgc_pkg::rsp_item_t e;
			int                  g;
			int unsigned         slot;
			int unsigned         s;
			e = '0;
			if (it.mode) begin
				if (it.bin_index <= MAX_WIN) begin
					e.bin_count = hist[it.bin_index];
					hist[it.bin_index] = '0;
				end
				e.status = swgc_pkg::ST_BIN_READ;
			end else begin
				if (it.first_of_region)
					restart_region();
				case (it.base) inside
					swgc_pkg::CH_C_LO, swgc_pkg::CH_C_UP,
					swgc_pkg::CH_G_LO, swgc_pkg::CH_G_UP: g = 1;
					swgc_pkg::CH_A_LO, swgc_pkg::CH_A_UP,
					swgc_pkg::CH_T_LO, swgc_pkg::CH_T_UP: g = 0;
					default: g = -1;
				endcase
				if (g < 0) begin
					e.status = swgc_pkg::ST_BAD_BASE;
				end else begin
					slot = (ring_ptr >= wl) ? 0 : ring_ptr;
					if (fill >= wl)
						gc_sum -= 32'(gc_ring[slot]);
					gc_sum += 32'(g);
					gc_ring[slot] = g[0];
					ring_ptr = (slot + 1 >= wl) ? 0 : slot + 1;
					if (fill < wl)
						fill++;
					if (fill >= wl) begin
						s = (gc_sum > MAX_WIN) ? MAX_WIN : gc_sum;
						if (hist[s] != '1)
							hist[s]++;
						if (total != '1)
							total++;
						e.status = swgc_pkg::ST_WINDOW;
						e.gc_count = swgc_pkg::GC_W'(s);
					end else begin
						e.status = swgc_pkg::ST_NO_WINDOW;
					end
				end
			end
			e.total_windows = total;
			pending_results.push_back(e);
		endfunction

		function void check_result(swgc_pkg::rsp_item_t got);
			swgc_pkg::rsp_item_t e;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			e = pending_results.pop_front();
			if (got.status !== e.status) begin
				$display("%0t: status expected %0d got %0d", $time, e.status, got.status);
				errors++;
			end
			if (got.gc_count !== e.gc_count) begin
				$display("%0t: gc_count expected %0d got %0d", $time, e.gc_count, got.gc_count);
				errors++;
			end
			if (got.bin_count !== e.bin_count) begin
				$display("%0t: bin_count expected %0d got %0d", $time, e.bin_count,
					got.bin_count);
				errors++;
			end
			if (got.total_windows !== e.total_windows) begin
				$display("%0t: total_windows expected %0d got %0d", $time, e.total_windows,
					got.total_windows);
				errors++;
			end
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       req_valid;
	logic                       req_ready;
	swgc_pkg::req_item_t        req;
	logic                       rsp_valid;
	logic                       rsp_ready;
	swgc_pkg::rsp_item_t        rsp;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [swgc_pkg::CFG_W-1:0] cfg_data;

	gc_hist_scoreboard sb;
	bit idle_on = 1'b1;
	int quiet_cycles = 0;
	int rsp_stall = 0;

	sliding_window_gc_histogram #(
		.MAX_WINDOW(MAX_WIN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			sb.check_result(rsp);
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("sliding_window_gc_histogram verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		rsp_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rsp_stall == 0 && idle_on && $urandom_range(5) == 0)
				rsp_stall = $urandom_range(1, 9);
			rsp_ready <= (rsp_stall == 0);
			if (rsp_stall != 0)
				rsp_stall--;
		end
	end

	function automatic swgc_pkg::req_item_t mk(logic m, logic [7:0] b, logic f,
			logic [swgc_pkg::BIN_IDX_W-1:0] idx);
		swgc_pkg::req_item_t it;
		it.mode = m;
		it.base = b;
		it.first_of_region = f;
		it.bin_index = idx;
		return it;
	endfunction

	function automatic logic [7:0] pick_base(bit gc);
		case ($urandom_range(3))
			0: return gc ? swgc_pkg::CH_C_LO : swgc_pkg::CH_A_LO;
			1: return gc ? swgc_pkg::CH_C_UP : swgc_pkg::CH_A_UP;
			2: return gc ? swgc_pkg::CH_G_LO : swgc_pkg::CH_T_LO;
			default: return gc ? swgc_pkg::CH_G_UP : swgc_pkg::CH_T_UP;
		endcase
	endfunction

	task automatic send_item(input swgc_pkg::req_item_t it);
		int gap;
		@(negedge clk);
		if (idle_on && $urandom_range(5) == 0) begin
			gap = $urandom_range(1, 9);
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req <= it;
		do @(posedge clk); while (!(req_valid && req_ready));
		sb.note_item(it);
	endtask

	// block goes idle: input dropped, all results back, pipeline flushed
	task automatic drain();
		@(negedge clk);
		req_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_window(input logic [swgc_pkg::CFG_W-1:0] v);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		sb.write_window(v);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase(input int n, input bit may_idle);
		swgc_pkg::req_item_t it;
		int left;
		int bias;
		int r;
		left = $urandom_range(0, 3);
		bias = $urandom_range(100);
		idle_on = may_idle && ($urandom_range(3) != 0);
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			it = mk(1'b0, 8'($urandom_range(255)), 1'($urandom_range(1)),
				swgc_pkg::BIN_IDX_W'($urandom_range(2047)));
			if (r < 10) begin
				it.mode = 1'b1;
				if (r >= 2)
					it.bin_index = swgc_pkg::BIN_IDX_W'($urandom_range(sb.wl));
			end else begin
				if (left == 0) begin
					left = $urandom_range(1, 2 * sb.wl + 4);
					bias = $urandom_range(100);
					it.first_of_region = 1'b1;
				end else begin
					it.first_of_region = ($urandom_range(49) == 0);
				end
				left--;
				if ($urandom_range(29) != 0)
					it.base = pick_base($urandom_range(99) < bias);
			end
			send_item(it);
		end
	endtask

	// one region as long as the widest window plus one, G/C except the last base
	task automatic long_region_phase();
		set_window(11'h7FF);
		idle_on = 1'b1;
		for (int i = 0; i < 1025; i++)
			send_item(mk(1'b0, pick_base(i < 1024), i == 0,
				swgc_pkg::BIN_IDX_W'($urandom_range(2047))));
		send_item(mk(1'b1, 8'($urandom_range(255)), 1'($urandom_range(1)), 11'd1024));
		send_item(mk(1'b1, 8'($urandom_range(255)), 1'($urandom_range(1)), 11'd1023));
		send_item(mk(1'b1, 8'($urandom_range(255)), 1'($urandom_range(1)), 11'd1025));
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// window of one after reset
		send_item(mk(1'b1, 8'h00, 1'b0, 11'd0));
		send_item(mk(1'b1, 8'hFF, 1'b1, 11'd1025));
		send_item(mk(1'b1, 8'h00, 1'b0, 11'h7FF));
		send_item(mk(1'b0, swgc_pkg::CH_A_UP, 1'b1, 11'd0));
		send_item(mk(1'b0, swgc_pkg::CH_C_LO, 1'b0, 11'h7FF));
		send_item(mk(1'b0, swgc_pkg::CH_G_UP, 1'b0, 11'd0));
		send_item(mk(1'b0, swgc_pkg::CH_G_LO, 1'b0, 11'd0));
		send_item(mk(1'b0, swgc_pkg::CH_C_UP, 1'b0, 11'd0));
		send_item(mk(1'b0, swgc_pkg::CH_A_LO, 1'b0, 11'd0));
		send_item(mk(1'b0, swgc_pkg::CH_T_LO, 1'b0, 11'd0));
		send_item(mk(1'b0, swgc_pkg::CH_T_UP, 1'b0, 11'd0));
		send_item(mk(1'b0, 8'h00, 1'b0, 11'd0));
		send_item(mk(1'b0, 8'hFF, 1'b0, 11'h7FF));
		send_item(mk(1'b0, "N", 1'b1, 11'd0));
		send_item(mk(1'b0, "u", 1'b0, 11'd0));
		send_item(mk(1'b1, swgc_pkg::CH_G_UP, 1'b1, 11'd1));
		send_item(mk(1'b1, 8'h00, 1'b0, 11'd1));
		send_item(mk(1'b1, 8'h00, 1'b0, 11'd0));
		send_item(mk(1'b1, 8'h00, 1'b0, 11'd1024));

		// bad base that opens a region still restarts the window
		set_window(11'd3);
		send_item(mk(1'b0, swgc_pkg::CH_G_UP, 1'b1, 11'd0));
		send_item(mk(1'b0, swgc_pkg::CH_G_LO, 1'b0, 11'd0));
		send_item(mk(1'b0, swgc_pkg::CH_G_UP, 1'b0, 11'd0));
		send_item(mk(1'b0, swgc_pkg::CH_A_UP, 1'b0, 11'd0));
		send_item(mk(1'b0, "N", 1'b1, 11'd0));
		send_item(mk(1'b0, swgc_pkg::CH_C_UP, 1'b0, 11'd0));
		send_item(mk(1'b0, swgc_pkg::CH_C_LO, 1'b0, 11'd0));
		send_item(mk(1'b0, swgc_pkg::CH_C_UP, 1'b0, 11'd0));
		send_item(mk(1'b1, 8'h00, 1'b0, 11'd3));
		send_item(mk(1'b1, 8'h00, 1'b0, 11'd2));

		set_window(11'd0);
		random_phase(10, 1'b1);
		set_window(11'd2);
		random_phase(10, 1'b1);
		set_window(11'd3);
		random_phase(10, 1'b1);
		set_window(11'd5);
		random_phase(10, 1'b1);
		set_window(swgc_pkg::CFG_W'($urandom_range(6, 40)));
		random_phase(10, 1'b1);
		long_region_phase();
		set_window(11'd1024);
		random_phase(6, 1'b1);
		set_window(11'd17);
		random_phase(10, 1'b1);
		idle_on = 1'b0;
		set_window(11'd1);
		random_phase(24, 1'b0);

		drain();
		if (sb.errors == 0)
			$display("sliding_window_gc_histogram verification clean");
		else
			$display("sliding_window_gc_histogram verification failed");
		$finish;
	end
endmodule
